// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at each rising clock edge, off while reset is low
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression that must never hold at a rising clock edge
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== design/jsud_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsud_pkg
// Types and constants shared by the string unescape decoder modules.
// ----------------------------------------------------------------------------
package jsud_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int CP_BITS     = 21;
  localparam int JOB_DEPTH   = 4;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } result_kind_e;

  typedef enum logic [3:0] {
    ERR_NONE           = 4'd0,
    ERR_EXPECTED_QUOTE = 4'd1,
    ERR_CONTROL_CHAR   = 4'd2,
    ERR_TRUNC_ESCAPE   = 4'd3,
    ERR_TRUNC_UNICODE  = 4'd4,
    ERR_BAD_HEX        = 4'd5,
    ERR_LONE_HIGH      = 4'd6,
    ERR_BAD_PAIR       = 4'd7,
    ERR_LONE_LOW       = 4'd8,
    ERR_BAD_ESCAPE     = 4'd9,
    ERR_UNTERMINATED   = 4'd10
  } error_code_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_marker;
  } in_word_t;

  typedef struct packed {
    logic [7:0]             out_byte;
    result_kind_e           result_kind;
    error_code_e            error_code;
    logic [OFFSET_BITS-1:0] err_offset;
    logic                   last_of_run;
  } out_word_t;

  // one queued job: a code point to encode, a done mark or an error
  typedef struct packed {
    result_kind_e           kind;
    logic [CP_BITS-1:0]     cp;
    logic [1:0]             last_idx;
    error_code_e            code;
    logic [OFFSET_BITS-1:0] offset;
  } job_t;

endpackage

// ===== design/json_string_unescape_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_decoder_top
// JSON string literal decoder with unescaping to UTF-8.
// ----------------------------------------------------------------------------
// Push the literal one byte per word, starting with the opening quote, or an
// end-of-text word. A new word is taken every cycle while the four-entry job
// queue between the classifier and the byte expander has room. Each word
// gives zero or one job; the expander turns a job into 1 to 4 result words
// at one word per cycle while the output register is empty or popped, and
// each job passes through the queue and then the output register. Results
// carry the decoded byte, a done mark or an error with its offset from the
// opening quote; last_of_run flags the final result of the input word that
// caused it.
module json_string_unescape_decoder_top #(
  parameter int POSITION_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  jsud_pkg::in_word_t  in_i,
  output logic                empty,
  input  logic                pop,
  output jsud_pkg::out_word_t result_o
);
  import jsud_pkg::*;

  logic in_valid;
  logic job_push;
  job_t job_in;
  logic job_valid;
  job_t job_head;
  logic job_pop;

  assign in_valid = push && !full;

  jsud_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_word_i  (in_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  jsud_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .data_o  (job_head)
  );

  jsud_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (result_o)
  );

endmodule

// ===== design/jsud_front.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// jsud_front
// Byte classifier and escape state machine; pushes one job per result run.
// ----------------------------------------------------------------------------
module jsud_front #(
  parameter int POSITION_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  jsud_pkg::in_word_t in_word_i,
  output logic               job_push_o,
  output jsud_pkg::job_t     job_o
);
  import jsud_pkg::*;

  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_BODY    = 7'b0000010,
    MODE_ESC     = 7'b0000100,
    MODE_HEX1    = 7'b0001000,
    MODE_PAIR_BS = 7'b0010000,
    MODE_PAIR_U  = 7'b0100000,
    MODE_HEX2    = 7'b1000000
  } mode_e;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [5:0] HIGH_TAG = 6'b110110;
  localparam logic [5:0] LOW_TAG  = 6'b110111;
  localparam logic [10:0] PLANE_ADD = 11'h040;

  localparam int WW = (POSITION_BITS >= OFFSET_BITS) ? POSITION_BITS + 1 : OFFSET_BITS + 1;
  localparam logic [WW-1:0] POS_MAX_W = WW'({POSITION_BITS{1'b1}});
  localparam logic [WW-1:0] OFF_MAX_W = WW'({OFFSET_BITS{1'b1}});

  function automatic logic [POSITION_BITS-1:0] sat_pos(input logic [WW-1:0] s);
    return (s > POS_MAX_W) ? {POSITION_BITS{1'b1}} : s[POSITION_BITS-1:0];
  endfunction

  function automatic logic [OFFSET_BITS-1:0] clamp_off(input logic [POSITION_BITS-1:0] p);
    logic [WW-1:0] w;
    w = WW'(p);
    return (w > OFF_MAX_W) ? {OFFSET_BITS{1'b1}} : w[OFFSET_BITS-1:0];
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c inside {[CH_0:CH_9]}) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c inside {[CH_LA:CH_LF]}) begin
      r = {1'b1, 4'(c - CH_LA + 8'd10)};
    end else if (c inside {[CH_UA:CH_UF]}) begin
      r = {1'b1, 4'(c - CH_UA + 8'd10)};
    end
    return r;
  endfunction

  function automatic job_t err_job(input error_code_e code,
                                   input logic [OFFSET_BITS-1:0] off);
    job_t j;
    j = '0;
    j.kind   = KIND_ERROR;
    j.code   = code;
    j.offset = off;
    return j;
  endfunction

  function automatic job_t data_job(input logic [CP_BITS-1:0] cp, input logic [1:0] last_idx);
    job_t j;
    j = '0;
    j.kind     = KIND_DATA;
    j.code     = ERR_NONE;
    j.cp       = cp;
    j.last_idx = last_idx;
    return j;
  endfunction

  mode_e                    mode_q, mode_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [POSITION_BITS-1:0] esc_q, esc_d;
  logic [15:0]              acc_q, acc_d;
  logic [1:0]               cnt_q, cnt_d;
  logic                     seen_q, seen_d;
  logic [1:0]               bidx_q, bidx_d;
  logic [9:0]               high_q, high_d;

  logic [7:0]  c;
  logic        in_end;
  logic [4:0]  hx;
  logic [15:0] acc_sh;
  logic        seen_n;
  logic [1:0]  bidx_n;
  logic        last_digit;
  logic [3:0]  base_k;
  logic [POSITION_BITS-1:0] pos_inc;
  logic [OFFSET_BITS-1:0]   off_pos, off_esc, off_base, off_bad;

  assign c      = in_word_i.in_byte;
  assign in_end = in_word_i.end_marker;
  assign hx     = hex_of(c);
  assign acc_sh = {acc_q[11:0], hx[4] ? hx[3:0] : 4'h0};
  assign seen_n = seen_q | ~hx[4];
  assign bidx_n = seen_q ? bidx_q : cnt_q;
  assign last_digit = (cnt_q == 2'd3);
  // the second hex group starts six bytes after the first
  assign base_k   = (mode_q == MODE_HEX2) ? 4'd8 : 4'd2;
  assign pos_inc  = sat_pos(WW'(pos_q) + WW'(1'b1));
  assign off_pos  = clamp_off(pos_q);
  assign off_esc  = clamp_off(esc_q);
  assign off_base = clamp_off(sat_pos(WW'(esc_q) + WW'(base_k)));
  assign off_bad  = clamp_off(sat_pos(WW'(esc_q) + WW'(base_k) + WW'(bidx_n)));

  always_comb begin
    mode_d     = mode_q;
    pos_d      = pos_q;
    esc_d      = esc_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    seen_d     = seen_q;
    bidx_d     = bidx_q;
    high_d     = high_q;
    job_push_o = 1'b0;
    job_o      = data_job('0, 2'd0);
    if (in_valid_i) begin
      if (!in_end) begin
        pos_d = pos_inc;
      end
      case (mode_q)
        MODE_BODY: begin
          if (in_end) begin
            job_push_o = 1'b1;
            job_o      = err_job(ERR_UNTERMINATED, '0);
            mode_d     = MODE_IDLE;
            pos_d      = '0;
          end else if (c == CH_QUOTE) begin
            job_push_o  = 1'b1;
            job_o       = '0;
            job_o.kind  = KIND_DONE;
            job_o.code  = ERR_NONE;
            mode_d      = MODE_IDLE;
            pos_d       = '0;
          end else if (c < CH_SPACE) begin
            job_push_o = 1'b1;
            job_o      = err_job(ERR_CONTROL_CHAR, off_pos);
            mode_d     = MODE_IDLE;
            pos_d      = '0;
          end else if (c == CH_BSLASH) begin
            esc_d  = pos_q;
            mode_d = MODE_ESC;
          end else begin
            job_push_o = 1'b1;
            job_o      = data_job(CP_BITS'(c), 2'd0);
          end
        end
        MODE_ESC: begin
          if (in_end) begin
            job_push_o = 1'b1;
            job_o      = err_job(ERR_TRUNC_ESCAPE, off_pos);
            mode_d     = MODE_IDLE;
            pos_d      = '0;
          end else if (c == CH_U) begin
            acc_d  = '0;
            cnt_d  = '0;
            seen_d = 1'b0;
            bidx_d = '0;
            mode_d = MODE_HEX1;
          end else if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH) begin
            job_push_o = 1'b1;
            job_o      = data_job(CP_BITS'(c), 2'd0);
            mode_d     = MODE_BODY;
          end else begin
            job_push_o = 1'b1;
            mode_d     = MODE_BODY;
            case (c)
              CH_B:    job_o = data_job(CP_BITS'(8'h08), 2'd0);
              CH_F:    job_o = data_job(CP_BITS'(8'h0C), 2'd0);
              CH_N:    job_o = data_job(CP_BITS'(8'h0A), 2'd0);
              CH_R:    job_o = data_job(CP_BITS'(8'h0D), 2'd0);
              CH_T:    job_o = data_job(CP_BITS'(8'h09), 2'd0);
              default: begin
                job_o  = err_job(ERR_BAD_ESCAPE, off_pos);
                mode_d = MODE_IDLE;
                pos_d  = '0;
              end
            endcase
          end
        end
        MODE_HEX1, MODE_HEX2: begin
          if (in_end) begin
            // truncation wins over any bad digit seen so far
            job_push_o = 1'b1;
            job_o      = err_job(ERR_TRUNC_UNICODE, off_base);
            mode_d     = MODE_IDLE;
            pos_d      = '0;
          end else begin
            acc_d  = acc_sh;
            seen_d = seen_n;
            bidx_d = bidx_n;
            if (!last_digit) begin
              cnt_d = cnt_q + 2'd1;
            end else if (seen_n) begin
              job_push_o = 1'b1;
              job_o      = err_job(ERR_BAD_HEX, off_bad);
              mode_d     = MODE_IDLE;
              pos_d      = '0;
            end else if (mode_q == MODE_HEX1) begin
              if (acc_sh[15:10] == HIGH_TAG) begin
                high_d = acc_sh[9:0];
                mode_d = MODE_PAIR_BS;
              end else if (acc_sh[15:10] == LOW_TAG) begin
                job_push_o = 1'b1;
                job_o      = err_job(ERR_LONE_LOW, off_esc);
                mode_d     = MODE_IDLE;
                pos_d      = '0;
              end else begin
                job_push_o = 1'b1;
                mode_d     = MODE_BODY;
                if (acc_sh < 16'h0080) begin
                  job_o = data_job(CP_BITS'(acc_sh), 2'd0);
                end else if (acc_sh < 16'h0800) begin
                  job_o = data_job(CP_BITS'(acc_sh), 2'd1);
                end else begin
                  job_o = data_job(CP_BITS'(acc_sh), 2'd2);
                end
              end
            end else if (acc_sh[15:10] != LOW_TAG) begin
              job_push_o = 1'b1;
              job_o      = err_job(ERR_BAD_PAIR, off_base);
              mode_d     = MODE_IDLE;
              pos_d      = '0;
            end else begin
              // 0x10000 + (high << 10 | low) folds into the upper bits
              job_push_o = 1'b1;
              job_o      = data_job({11'(high_q) + PLANE_ADD, acc_sh[9:0]}, 2'd3);
              mode_d     = MODE_BODY;
            end
          end
        end
        MODE_PAIR_BS: begin
          if (in_end || c != CH_BSLASH) begin
            job_push_o = 1'b1;
            job_o      = err_job(ERR_LONE_HIGH, off_esc);
            mode_d     = MODE_IDLE;
            pos_d      = '0;
          end else begin
            mode_d = MODE_PAIR_U;
          end
        end
        MODE_PAIR_U: begin
          if (in_end || c != CH_U) begin
            job_push_o = 1'b1;
            job_o      = err_job(ERR_LONE_HIGH, off_esc);
            mode_d     = MODE_IDLE;
            pos_d      = '0;
          end else begin
            acc_d  = '0;
            cnt_d  = '0;
            seen_d = 1'b0;
            bidx_d = '0;
            mode_d = MODE_HEX2;
          end
        end
        default: begin
          // idle: only an opening quote starts a string
          if (in_end || c != CH_QUOTE) begin
            job_push_o = 1'b1;
            job_o      = err_job(ERR_EXPECTED_QUOTE, '0);
            mode_d     = MODE_IDLE;
            pos_d      = '0;
          end else begin
            mode_d = MODE_BODY;
            pos_d  = POSITION_BITS'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      pos_q  <= '0;
      esc_q  <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
      seen_q <= 1'b0;
      bidx_q <= '0;
      high_q <= '0;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      esc_q  <= esc_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      seen_q <= seen_d;
      bidx_q <= bidx_d;
      high_q <= high_d;
    end
  end

  `ASSERT_AT(a_idle_pos_zero, clk_i, rst_ni, mode_q == MODE_IDLE |-> pos_q == '0, "position not cleared in idle")
  `ASSERT_AT(a_error_to_idle, clk_i, rst_ni, job_push_o && job_o.kind == KIND_ERROR |=> mode_q == MODE_IDLE, "no return to idle after error")

endmodule

// ===== design/jsud_fifo.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// jsud_fifo
// Short job queue between the classifier and the byte expander.
// ----------------------------------------------------------------------------
module jsud_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jsud_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output jsud_pkg::job_t data_o
);
  import jsud_pkg::*;

  localparam int AW = $clog2(JOB_DEPTH);

  job_t          mem_q [JOB_DEPTH];
  logic [AW-1:0] wr_q, wr_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [AW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (AW + 1)'(JOB_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o, "job pushed into full queue")
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && !valid_o, "job popped from empty queue")

endmodule

// ===== design/jsud_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// jsud_back
// Expands queued jobs into result words, one word per cycle while the output
// register is empty or popped, into that output register.
// ----------------------------------------------------------------------------
module jsud_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  jsud_pkg::job_t      job_i,
  output logic                job_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output jsud_pkg::out_word_t result_o
);
  import jsud_pkg::*;

  // byte idx of a utf-8 sequence whose last byte has index last_idx
  function automatic logic [7:0] utf8_byte(input logic [CP_BITS-1:0] cp,
                                           input logic [1:0] last_idx,
                                           input logic [1:0] idx);
    logic [1:0] from_end;
    logic [7:0] b;
    from_end = last_idx - idx;
    if (idx == 2'd0) begin
      case (last_idx)
        2'd0:    b = cp[7:0];
        2'd1:    b = {3'b110, cp[10:6]};
        2'd2:    b = {4'b1110, cp[15:12]};
        default: b = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (from_end)
        2'd0:    b = {2'b10, cp[5:0]};
        2'd1:    b = {2'b10, cp[11:6]};
        2'd2:    b = {2'b10, cp[17:12]};
        default: b = {2'b10, cp[5:0]};
      endcase
    end
    return b;
  endfunction

  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;
  logic [1:0] idx_q, idx_d;
  logic      load;
  logic      is_last;

  assign load      = job_valid_i && (!out_valid_q || pop_i);
  assign is_last   = (idx_q == job_i.last_idx);
  assign job_pop_o = load && is_last;
  assign empty_o   = !out_valid_q;
  assign result_o  = out_q;

  always_comb begin
    out_d              = out_q;
    out_valid_d        = out_valid_q;
    idx_d              = idx_q;
    if (load) begin
      out_d.out_byte     = (job_i.kind == KIND_DATA) ?
                           utf8_byte(job_i.cp, job_i.last_idx, idx_q) : 8'h00;
      out_d.result_kind  = job_i.kind;
      out_d.error_code   = job_i.code;
      out_d.err_offset   = job_i.offset;
      out_d.last_of_run  = is_last;
      out_valid_d        = 1'b1;
      idx_d              = is_last ? 2'd0 : idx_q + 2'd1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  `ASSERT_AT(a_single_word_last, clk_i, rst_ni, out_valid_q && out_q.result_kind != KIND_DATA |-> out_q.last_of_run, "done or error word not marked last")
  `ASSERT_AT(a_idx_needs_job, clk_i, rst_ni, idx_q != 2'd0 |-> job_valid_i, "sequence index left without a job")

endmodule

// ===== tb/json_string_unescape_decoder_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_decoder_top_test
// Pushes JSON string literals through the unescape decoder one byte word at a
// time: a directed opening, then random literals, about half well formed
// with random content, the rest broken in each way the decoder reports, plus
// stray words while idle. A local decoder model predicts every result word,
// and each popped word is checked field by field against the oldest
// prediction. Both sides idle in random bursts, the receiver holds off once
// for a long stretch, and the sender pauses once until all results are in.
// ----------------------------------------------------------------------------
module json_string_unescape_decoder_top_test;
  import jsud_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] ESC_LETTERS [8] = '{8'h22, 8'h5C, "/", "b", "f", "n", "r", "t"};

  localparam int unsigned END_CYCLES = 20;
  localparam int unsigned LONG_HOLD  = 80;
  localparam int unsigned HOLD_AFTER = 120;
  localparam int unsigned TAIL_WORDS = 40;
  localparam int unsigned PAUSE_AT   = 190;
  localparam int unsigned TEXT_WORDS = 365;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_BODY, MODE_ESC, MODE_HEX1, MODE_PAIR_BS, MODE_PAIR_U, MODE_HEX2
  } mode_e;

  typedef enum int {
    FL_CTRL, FL_TRUNC_ESC, FL_BAD_ESC, FL_TRUNC_UNI, FL_BAD_HEX,
    FL_LONE_HIGH, FL_BAD_PAIR, FL_LONE_LOW, FL_UNTERM, FL_IDLE_JUNK
  } flaw_e;

  typedef struct {
    in_word_t word;
    bit       drain;
  } text_item_t;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push   = 1'b0;
  logic      pop    = 1'b0;
  logic      full;
  logic      empty;
  in_word_t  in_word = '0;
  out_word_t out_word;

  text_item_t  text_words[$];
  out_word_t   decoded_words[$];
  out_word_t   want_word;

  int unsigned words_sent;
  int unsigned ends_made;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned kind_seen [3];
  int unsigned send_gap;
  int unsigned send_idle_pct;
  int unsigned hold_left;
  int unsigned recv_idle_pct;
  bit          long_hold_done;

  // decoder model state
  mode_e                  dec_mode  = MODE_IDLE;
  logic [OFFSET_BITS-1:0] dec_pos   = '0;
  logic [OFFSET_BITS-1:0] esc_pos   = '0;
  logic [15:0]            hex_acc   = '0;
  logic [1:0]             hex_cnt   = '0;
  logic                   bad_seen  = 1'b0;
  logic [1:0]             bad_idx   = '0;
  logic [9:0]             high_bits = '0;
  out_word_t              step_out[$];

  json_string_unescape_decoder_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .in_i     (in_word),
    .empty    (empty),
    .pop      (pop),
    .result_o (out_word)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [OFFSET_BITS-1:0] pos_add(logic [OFFSET_BITS-1:0] a,
                                                     int unsigned b);
    logic [OFFSET_BITS:0] s;
    s = {1'b0, a} + (OFFSET_BITS + 1)'(b);
    return s[OFFSET_BITS] ? '1 : s[OFFSET_BITS-1:0];
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void add_result(result_kind_e kind, logic [7:0] b, error_code_e code,
                                     logic [OFFSET_BITS-1:0] off);
    out_word_t w;
    w.out_byte     = b;
    w.result_kind  = kind;
    w.error_code   = code;
    w.err_offset   = off;
    w.last_of_run  = 1'b0;
    step_out.push_back(w);
  endfunction

  function automatic void fault(error_code_e code, logic [OFFSET_BITS-1:0] off);
    add_result(KIND_ERROR, 8'h00, code, off);
    dec_mode = MODE_IDLE;
    dec_pos  = '0;
  endfunction

  function automatic void data_byte(logic [7:0] b);
    add_result(KIND_DATA, b, ERR_NONE, '0);
  endfunction

  function automatic void emit_utf8(logic [20:0] cp);
    if (cp < 21'h80) begin
      data_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      data_byte({3'b110, cp[10:6]});
      data_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      data_byte({4'b1110, cp[15:12]});
      data_byte({2'b10, cp[11:6]});
      data_byte({2'b10, cp[5:0]});
    end else begin
      data_byte({5'b11110, cp[20:18]});
      data_byte({2'b10, cp[17:12]});
      data_byte({2'b10, cp[11:6]});
      data_byte({2'b10, cp[5:0]});
    end
  endfunction

  function automatic void clear_hex();
    hex_acc  = '0;
    hex_cnt  = '0;
    bad_seen = 1'b0;
    bad_idx  = '0;
  endfunction

  // true once the fourth digit of the group is in; a bad digit counts as zero
  function automatic bit take_hex_digit(logic [7:0] c);
    int h;
    h = hex_value(c);
    if (h < 0) begin
      if (!bad_seen) begin
        bad_seen = 1'b1;
        bad_idx  = hex_cnt;
      end
      h = 0;
    end
    hex_acc = {hex_acc[11:0], 4'(h)};
    if (hex_cnt == 2'd3) return 1'b1;
    hex_cnt++;
    return 1'b0;
  endfunction

  function automatic void unescape_step(in_word_t w);
    logic [7:0]             c;
    logic                   fin;
    logic [OFFSET_BITS-1:0] here;
    logic [OFFSET_BITS-1:0] base;
    c    = w.in_byte;
    fin  = w.end_marker;
    here = dec_pos;
    step_out.delete();
    if (dec_mode == MODE_IDLE) begin
      if (fin || c != CH_QUOTE) begin
        fault(ERR_EXPECTED_QUOTE, '0);
      end else begin
        dec_mode = MODE_BODY;
        dec_pos  = pos_add('0, 1);
      end
    end else begin
      if (!fin) dec_pos = pos_add(here, 1);
      case (dec_mode)
        MODE_BODY: begin
          if (fin) begin
            fault(ERR_UNTERMINATED, '0);
          end else if (c == CH_QUOTE) begin
            add_result(KIND_DONE, 8'h00, ERR_NONE, '0);
            dec_mode = MODE_IDLE;
            dec_pos  = '0;
          end else if (c < 8'h20) begin
            fault(ERR_CONTROL_CHAR, here);
          end else if (c == CH_BSLASH) begin
            esc_pos  = here;
            dec_mode = MODE_ESC;
          end else begin
            data_byte(c);
          end
        end
        MODE_ESC: begin
          if (fin) begin
            fault(ERR_TRUNC_ESCAPE, here);
          end else if (c == CH_U) begin
            clear_hex();
            dec_mode = MODE_HEX1;
          end else begin
            case (c)
              CH_QUOTE, CH_BSLASH, "/": data_byte(c);
              "b":     data_byte(8'h08);
              "f":     data_byte(8'h0C);
              "n":     data_byte(8'h0A);
              "r":     data_byte(8'h0D);
              "t":     data_byte(8'h09);
              default: fault(ERR_BAD_ESCAPE, here);
            endcase
            if (dec_mode == MODE_ESC) dec_mode = MODE_BODY;
          end
        end
        MODE_HEX1: begin
          base = pos_add(esc_pos, 2);
          if (fin) begin
            fault(ERR_TRUNC_UNICODE, base);
          end else if (take_hex_digit(c)) begin
            if (bad_seen) begin
              fault(ERR_BAD_HEX, pos_add(base, 32'(bad_idx)));
            end else if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
              high_bits = hex_acc[9:0];
              dec_mode  = MODE_PAIR_BS;
            end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
              fault(ERR_LONE_LOW, esc_pos);
            end else begin
              dec_mode = MODE_BODY;
              emit_utf8({5'b0, hex_acc});
            end
          end
        end
        MODE_PAIR_BS: begin
          if (fin || c != CH_BSLASH) fault(ERR_LONE_HIGH, esc_pos);
          else dec_mode = MODE_PAIR_U;
        end
        MODE_PAIR_U: begin
          if (fin || c != CH_U) begin
            fault(ERR_LONE_HIGH, esc_pos);
          end else begin
            clear_hex();
            dec_mode = MODE_HEX2;
          end
        end
        default: begin
          base = pos_add(esc_pos, 8);
          if (fin) begin
            fault(ERR_TRUNC_UNICODE, base);
          end else if (take_hex_digit(c)) begin
            if (bad_seen) begin
              fault(ERR_BAD_HEX, pos_add(base, 32'(bad_idx)));
            end else if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
              fault(ERR_BAD_PAIR, base);
            end else begin
              dec_mode = MODE_BODY;
              emit_utf8(21'h10000 + {1'b0, high_bits, hex_acc[9:0]});
            end
          end
        end
      endcase
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last_of_run = 1'b1;
    foreach (step_out[i]) decoded_words.push_back(step_out[i]);
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic void add_byte(logic [7:0] b);
    text_item_t t;
    t.word.in_byte    = b;
    t.word.end_marker = 1'b0;
    t.drain           = 1'b0;
    text_words.push_back(t);
  endfunction

  // the byte lane carries noise with an end mark, the decoder must ignore it
  function automatic void add_end();
    text_item_t t;
    t.word.in_byte    = 8'($urandom);
    t.word.end_marker = 1'b1;
    t.drain           = 1'b0;
    text_words.push_back(t);
    ends_made++;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n - 4'd10);
  endfunction

  function automatic logic [7:0] byte_except(logic [7:0] x);
    logic [7:0] b;
    do b = 8'($urandom); while (b == x);
    return b;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] b;
    do b = 8'($urandom); while (hex_value(b) >= 0);
    return b;
  endfunction

  function automatic logic [7:0] loose_digit();
    return ($urandom_range(0, 3) == 0) ? non_hex_char() : hex_char(4'($urandom));
  endfunction

  function automatic logic [15:0] rand_high();
    return 16'($urandom_range(16'hD800, 16'hDBFF));
  endfunction

  function automatic void add_unicode(logic [15:0] v);
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    for (int i = 3; i >= 0; i--) add_byte(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic void fill_random(int unsigned target);
    logic [7:0]  b;
    logic [15:0] v;
    int          bad_at;
    while (text_words.size() < target) begin
      if ($urandom_range(0, 14) == 0) begin
        // stray word outside any literal
        if ($urandom_range(0, 1)) add_end();
        else add_byte(8'($urandom));
        continue;
      end
      add_byte(CH_QUOTE);
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 5))
          0, 1: begin
            do b = 8'($urandom_range(8'h20, 8'h7E)); while (b == CH_QUOTE || b == CH_BSLASH);
            add_byte(b);
          end
          2: add_byte(8'($urandom_range(8'h80, 8'hFF)));
          3: begin
            add_byte(CH_BSLASH);
            add_byte(ESC_LETTERS[$urandom_range(0, 7)]);
          end
          4: begin
            case ($urandom_range(0, 2))
              0: v = 16'($urandom_range(0, 16'h7F));
              1: v = 16'($urandom_range(16'h80, 16'h7FF));
              default: begin
                do v = 16'($urandom_range(16'h800, 16'hFFFF));
                while (v >= 16'hD800 && v <= 16'hDFFF);
              end
            endcase
            add_unicode(v);
          end
          default: begin
            add_unicode(rand_high());
            add_unicode(16'($urandom_range(16'hDC00, 16'hDFFF)));
          end
        endcase
      end
      if ($urandom_range(0, 1)) begin
        add_byte(CH_QUOTE);
      end else begin
        case (flaw_e'($urandom_range(FL_CTRL, FL_IDLE_JUNK)))
          FL_CTRL: add_byte(8'($urandom_range(0, 8'h1F)));
          FL_TRUNC_ESC: begin
            add_byte(CH_BSLASH);
            add_end();
          end
          FL_BAD_ESC: begin
            do b = 8'($urandom);
            while (b inside {CH_U, CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"});
            add_byte(CH_BSLASH);
            add_byte(b);
          end
          FL_TRUNC_UNI: begin
            if ($urandom_range(0, 1)) add_unicode(rand_high());
            add_byte(CH_BSLASH);
            add_byte(CH_U);
            // a bad digit here must lose to the truncation
            repeat ($urandom_range(0, 3)) add_byte(loose_digit());
            add_end();
          end
          FL_BAD_HEX: begin
            if ($urandom_range(0, 1)) add_unicode(rand_high());
            add_byte(CH_BSLASH);
            add_byte(CH_U);
            bad_at = $urandom_range(0, 3);
            for (int i = 0; i < 4; i++) add_byte(i == bad_at ? non_hex_char() : loose_digit());
          end
          FL_LONE_HIGH: begin
            add_unicode(rand_high());
            case ($urandom_range(0, 3))
              0: add_end();
              1: add_byte(byte_except(CH_BSLASH));
              2: begin
                add_byte(CH_BSLASH);
                add_end();
              end
              default: begin
                add_byte(CH_BSLASH);
                add_byte(byte_except(CH_U));
              end
            endcase
          end
          FL_BAD_PAIR: begin
            add_unicode(rand_high());
            do v = 16'($urandom); while (v >= 16'hDC00 && v <= 16'hDFFF);
            add_unicode(v);
          end
          FL_LONE_LOW: add_unicode(16'($urandom_range(16'hDC00, 16'hDFFF)));
          FL_UNTERM: add_end();
          default: begin
            // closed literal followed by junk while idle
            add_byte(CH_QUOTE);
            if ($urandom_range(0, 1)) add_end();
            else add_byte(byte_except(CH_QUOTE));
          end
        endcase
      end
    end
  endfunction

  function automatic bit in_tail();
    return text_words.size() < TAIL_WORDS;
  endfunction

  function automatic void check_field(string name, logic [OFFSET_BITS-1:0] want,
                                      logic [OFFSET_BITS-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------- acceptance, checking

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        unescape_step(in_word);
        void'(text_words.pop_front());
        words_sent++;
      end
      if (pop && !empty) begin
        results_seen++;
        if (decoded_words.size() == 0) begin
          $error("unexpected result word: kind %0d byte 0x%0h code %0d",
                 out_word.result_kind, out_word.out_byte, out_word.error_code);
          mismatches++;
        end else begin
          want_word = decoded_words.pop_front();
          kind_seen[want_word.result_kind]++;
          check_field("out_byte", OFFSET_BITS'(want_word.out_byte),
                      OFFSET_BITS'(out_word.out_byte));
          check_field("result_kind", OFFSET_BITS'(want_word.result_kind),
                      OFFSET_BITS'(out_word.result_kind));
          check_field("error_code", OFFSET_BITS'(want_word.error_code),
                      OFFSET_BITS'(out_word.error_code));
          check_field("err_offset", want_word.err_offset, out_word.err_offset);
          check_field("last_of_run", OFFSET_BITS'(want_word.last_of_run),
                      OFFSET_BITS'(out_word.last_of_run));
        end
      end
    end
  end

  // ----------------------------------------------------------------- driver

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 59) == 0) send_idle_pct = 15 * $urandom_range(0, 2);
      if (send_gap > 0) begin
        push <= 1'b0;
        send_gap--;
      end else if (text_words.size() == 0) begin
        push <= 1'b0;
      end else if (text_words[0].drain) begin
        // hold until every predicted word has been popped
        push <= 1'b0;
        if (decoded_words.size() == 0) void'(text_words.pop_front());
      end else if (!in_tail() && $urandom_range(0, 99) < send_idle_pct) begin
        push     <= 1'b0;
        send_gap  = $urandom_range(0, 6);
      end else begin
        push    <= 1'b1;
        in_word <= text_words[0].word;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 59) == 0) recv_idle_pct = 15 * $urandom_range(0, 2);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        // long hold-off so the job queue fills and full backs up the sender
        pop            <= 1'b0;
        hold_left       = LONG_HOLD - 1;
        long_hold_done  = 1'b1;
      end else if (!in_tail() && $urandom_range(0, 99) < recv_idle_pct) begin
        pop       <= 1'b0;
        hold_left  = $urandom_range(0, 6);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------- sequence

  initial begin
    text_item_t pause_mark;
    pause_mark.word  = '0;
    pause_mark.drain = 1'b1;

    // idle without a quote, end while idle, control byte in the body
    add_byte(8'h00);
    add_end();
    add_byte(CH_QUOTE);
    add_byte(8'h1F);
    // high byte through, code point zero, highest pair, end in the body
    add_byte(CH_QUOTE);
    add_byte(8'hFF);
    add_unicode(16'h0000);
    add_unicode(16'hDBFF);
    add_unicode(16'hDFFF);
    add_end();

    fill_random(PAUSE_AT);
    text_words.push_back(pause_mark);
    fill_random(TEXT_WORDS);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (text_words.size() != 0) @(posedge clk_i);
    while (decoded_words.size() != 0) @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);

    $display("pushed %0d words (%0d end marks), popped %0d results", words_sent, ends_made,
             results_seen);
    $display("data %0d, done %0d, error %0d, mismatches %0d", kind_seen[KIND_DATA],
             kind_seen[KIND_DONE], kind_seen[KIND_ERROR], mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== json_string_unescape_decoder_top.f =====
+incdir+design
design/jsud_pkg.sv
design/jsud_front.sv
design/jsud_fifo.sv
design/jsud_back.sv
design/json_string_unescape_decoder_top.sv
tb/json_string_unescape_decoder_top_test.sv
